@@ rtl/core/mdsd_pkg.sv @@
// shared types, constants and the digit decode function for the dashboard segment driver
`timescale 1ns / 1ps
package mdsd_pkg;

  // number of multiplexed COM groups
  localparam int unsigned SCAN_GROUPS = 3;

  localparam logic [7:0] SPEED_MAX    = 8'd99;
  localparam logic [7:0] BLINK_ON     = 8'd10;
  localparam logic [7:0] BLINK_PERIOD = 8'd20;

  // group 2 icon bits
  localparam logic [14:0] ICON_OIL  = 15'h0100;
  localparam logic [14:0] ICON_UNIT = 15'h0002;
  localparam logic [14:0] BAR_1     = 15'h6000;
  localparam logic [14:0] BAR_2     = 15'h1800;
  localparam logic [14:0] BAR_3     = 15'h0600;
  localparam logic [14:0] BAR_4     = 15'h0048;
  localparam logic [14:0] BAR_5     = 15'h0014;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_SCAN   = 1'b1
  } op_t;

  typedef logic [1:0]  scan_idx_t;
  typedef logic [14:0] seg_word_t;
  typedef logic [2:0]  com_t;

  // decoded display content, held by the top level
  typedef struct packed {
    seg_word_t speed_word;
    seg_word_t icon_word;
  } content_t;

  // one scan beat plus the following index
  typedef struct packed {
    seg_word_t word;
    com_t      com;
    scan_idx_t idx_nxt;
  } scan_beat_t;

  // seven-segment pattern, bits 0..6 = segments a..g
  function automatic logic [6:0] digit_segments(input logic [3:0] d);
    logic [6:0] seg;
    unique case (d)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/core/mdsd_if.sv @@
// valid/ready channel interfaces for input ticks and segment beats
`timescale 1ns / 1ps
interface mdsd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] speed;
  logic [7:0] battery_level;

  modport source (output valid, output operation, output speed, output battery_level,
                  input ready);
  modport sink   (input valid, input operation, input speed, input battery_level,
                  output ready);
endinterface

interface mdsd_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] segment_word;
  logic [2:0]  com_select;

  modport source (output valid, output segment_word, output com_select, input ready);
  modport sink   (input valid, input segment_word, input com_select, output ready);
endinterface

@@ rtl/core/mdsd_content_decode.sv @@
// speed digits and icon/battery word decode for an update tick
`timescale 1ns / 1ps
module mdsd_content_decode (
  input  logic              [7:0] speed,
  input  logic              [7:0] battery_level,
  input  logic              [7:0] blink_count,
  output mdsd_pkg::content_t      content
);

  logic [6:0]  spd_c;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  units;
  logic [15:0] blink_prod;
  logic [3:0]  blink_q;
  logic [7:0]  blink_rem;
  logic [6:0]  tens_seg;
  logic [6:0]  units_seg;
  logic [14:0] icons;

  // clamp and split into decimal digits, tens = floor(s * 205 / 2048) exact below 100
  always_comb begin
    spd_c     = (speed > mdsd_pkg::SPEED_MAX) ? mdsd_pkg::SPEED_MAX[6:0] : speed[6:0];
    tens_prod = 15'(spd_c) * 15'd205;
    tens      = tens_prod[14:11];
    units     = spd_c - 7'(tens) * 7'd10;
    tens_seg  = mdsd_pkg::digit_segments(tens);
    units_seg = mdsd_pkg::digit_segments(units[3:0]);
  end

  // blink phase: count mod 20 via reciprocal, exact over 8 bits
  always_comb begin
    blink_prod = 16'(blink_count) * 16'd205;
    blink_q    = blink_prod[15:12];
    blink_rem  = blink_count - 8'(blink_q) * mdsd_pkg::BLINK_PERIOD;
  end

  // unit icon, battery bars and oil-can icon
  always_comb begin
    icons = mdsd_pkg::ICON_UNIT;
    if (battery_level == 8'd0) begin
      if (blink_rem < mdsd_pkg::BLINK_ON) begin
        icons = icons | mdsd_pkg::ICON_OIL;
      end
    end else if (battery_level <= 8'd5) begin
      icons = icons | mdsd_pkg::BAR_1;
      if (battery_level >= 8'd2) icons = icons | mdsd_pkg::BAR_2;
      if (battery_level >= 8'd3) icons = icons | mdsd_pkg::BAR_3;
      if (battery_level >= 8'd4) icons = icons | mdsd_pkg::BAR_4;
      if (battery_level == 8'd5) icons = icons | mdsd_pkg::BAR_5;
    end
  end

  // tens digit blank below 10
  assign content.speed_word = {(tens != 4'd0) ? tens_seg : 7'd0, 1'b0, units_seg};
  assign content.icon_word  = icons;

endmodule

@@ rtl/core/mdsd_scan_mux.sv @@
// scan group select: word, one-hot COM and next index
`timescale 1ns / 1ps
module mdsd_scan_mux (
  input  mdsd_pkg::scan_idx_t  scan_index,
  input  mdsd_pkg::content_t   content,
  output mdsd_pkg::scan_beat_t beat
);

  logic [2:0] idx_inc;

  assign idx_inc = 3'(scan_index) + 3'd1;

  always_comb begin
    unique case (scan_index)
      2'd0: begin
        beat.word = content.speed_word;
        beat.com  = 3'b001;
      end
      2'd1: begin
        beat.word = content.speed_word;
        beat.com  = 3'b010;
      end
      2'd2: begin
        beat.word = content.icon_word;
        beat.com  = 3'b100;
      end
      default: begin
        beat.word = '0;
        beat.com  = '0;
      end
    endcase
    // wrap at the group count, out-of-range index falls back to group 0
    if (idx_inc >= 3'(mdsd_pkg::SCAN_GROUPS)) begin
      beat.idx_nxt = '0;
    end else begin
      beat.idx_nxt = idx_inc[1:0];
    end
  end

endmodule

@@ rtl/core/multiplexed_dashboard_segment_driver_core.sv @@
// top level: input register, content/scan state, output beat register
// a scan or init tick is held in the input register, then its beat in the output beat register
// throughput: one tick per cycle; update ticks after the first give no beat and never wait on the output
// a tick with a beat stalls only while the output register holds an untaken beat
// reset (rst_n low, synchronous) empties both registers and clears the display state;
// the first tick after reset yields a blank beat with all COM lines off
`timescale 1ns / 1ps
module multiplexed_dashboard_segment_driver_core (
  input  logic        clk,
  input  logic        rst_n,
  mdsd_in_if.sink     in_ch,
  mdsd_out_if.source  out_ch
);

  logic                 s1_valid_r;
  logic                 s1_op_r;
  logic [7:0]           s1_speed_r;
  logic [7:0]           s1_level_r;

  logic                 init_r;
  mdsd_pkg::content_t   content_r;
  mdsd_pkg::content_t   content_nxt;
  logic [7:0]           blink_r;
  logic [7:0]           blink_nxt;
  mdsd_pkg::scan_idx_t  scan_idx_r;

  logic                 out_valid_r;
  mdsd_pkg::seg_word_t  out_word_r;
  mdsd_pkg::com_t       out_com_r;

  logic                 has_beat;
  logic                 s1_fire;
  mdsd_pkg::scan_beat_t beat;

  // stage control
  assign has_beat    = !init_r || (s1_op_r == mdsd_pkg::OP_SCAN);
  assign s1_fire     = s1_valid_r && (!has_beat || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign blink_nxt   = blink_r + 8'd1;

  mdsd_content_decode u_decode (
    .speed         (s1_speed_r),
    .battery_level (s1_level_r),
    .blink_count   (blink_nxt),
    .content       (content_nxt)
  );

  mdsd_scan_mux u_scan (
    .scan_index (scan_idx_r),
    .content    (content_r),
    .beat       (beat)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r    <= in_ch.operation;
      s1_speed_r <= in_ch.speed;
      s1_level_r <= in_ch.battery_level;
    end
  end

  // display state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r     <= 1'b0;
      content_r  <= '0;
      blink_r    <= '0;
      scan_idx_r <= '0;
    end else if (s1_fire) begin
      if (!init_r) begin
        init_r    <= 1'b1;
        content_r <= '0;
      end else if (s1_op_r == mdsd_pkg::OP_UPDATE) begin
        content_r <= content_nxt;
        blink_r   <= blink_nxt;
      end else begin
        scan_idx_r <= beat.idx_nxt;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && has_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_beat) begin
      out_word_r <= init_r ? beat.word : '0;
      out_com_r  <= init_r ? beat.com  : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.segment_word = out_word_r;
  assign out_ch.com_select   = out_com_r;

  // checks
  a_com_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_com_r))
    else $error("com select not one-hot");

  a_no_beat_before_init: assert property (@(posedge clk) disable iff (!rst_n)
    !init_r |-> !out_valid_r)
    else $error("beat before init tick");

  a_scan_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r != 2'd3)
    else $error("scan index out of range");

  a_beat_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && has_beat) |=> out_valid_r)
    else $error("beat lost");

endmodule
